// ===== sv/lwps_pkg.sv =====
// ----------------------------------------------------------------------------
// lwps_pkg
// Shared types and constants for the LCD window and pixel streamer.
// ----------------------------------------------------------------------------
`default_nettype none

package lwps_pkg;

   // display command codes
   localparam logic [7:0] CMD_COLUMN = 8'h2a;
   localparam logic [7:0] CMD_ROW    = 8'h2b;
   localparam logic [7:0] CMD_WRITE  = 8'h2c;
   localparam logic [7:0] PAD_BYTE   = 8'h00;

   // byte counts per item kind
   localparam int unsigned WIN_BYTES = 22;
   localparam int unsigned PIX_BYTES = 2;
   localparam int unsigned IDX_W     = 5;

   localparam logic [IDX_W-1:0] WIN_LAST_IDX = IDX_W'(WIN_BYTES - 1);
   localparam logic [IDX_W-1:0] PIX_LAST_IDX = IDX_W'(PIX_BYTES - 1);

   // pair slots of a window sequence (each pair is pad byte + value byte)
   localparam logic [3:0] PAIR_COL_CMD = 4'd0;
   localparam logic [3:0] PAIR_XS_HI   = 4'd1;
   localparam logic [3:0] PAIR_XS_LO   = 4'd2;
   localparam logic [3:0] PAIR_XE_HI   = 4'd3;
   localparam logic [3:0] PAIR_XE_LO   = 4'd4;
   localparam logic [3:0] PAIR_ROW_CMD = 4'd5;
   localparam logic [3:0] PAIR_YS_HI   = 4'd6;
   localparam logic [3:0] PAIR_YS_LO   = 4'd7;
   localparam logic [3:0] PAIR_YE_HI   = 4'd8;
   localparam logic [3:0] PAIR_YE_LO   = 4'd9;
   localparam logic [3:0] PAIR_WR_CMD  = 4'd10;

   // one classified job handed from front to back
   typedef struct packed {
      logic        is_pixel;
      logic        dc_data;
      logic [8:0]  x_start;
      logic [15:0] x_end;
      logic [8:0]  y_start;
      logic [15:0] y_end;
      logic [15:0] pixel_value;
      logic        window_done;
   } lwps_entry_type;

endpackage

`default_nettype wire

// ===== sv/lwps_front.sv =====
// ----------------------------------------------------------------------------
// lwps_front
// Accepts input words, classifies them, computes window end coordinates and
// tracks the remaining pixel count of the open window.
// ----------------------------------------------------------------------------
`default_nettype none

module lwps_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic                    csr_wr_data,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [55:0]             req_tdata,
   input  wire logic                    req_tuser,
   output logic                         push_valid,
   input  wire logic                    push_ready,
   output lwps_pkg::lwps_entry_type     push_entry
);

   logic        dc_active_ff;
   logic        dc_active_in;
   logic [17:0] pixels_left_ff;
   logic [17:0] pixels_left_in;

   logic [8:0]  x_start;
   logic [8:0]  y_start;
   logic [8:0]  win_width;
   logic [8:0]  win_height;
   logic [15:0] pixel_value;
   logic        accept;

   assign x_start     = req_tdata[8:0];
   assign y_start     = req_tdata[17:9];
   assign win_width   = req_tdata[26:18];
   assign win_height  = req_tdata[35:27];
   assign pixel_value = req_tdata[51:36];

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      dc_active_in = csr_wr_en ? csr_wr_data : dc_active_ff;

      pixels_left_in = pixels_left_ff;
      if (accept) begin
         if (!req_tuser) begin
            pixels_left_in = {9'd0, win_width} * {9'd0, win_height};
         end else if (pixels_left_ff != 18'd0) begin
            pixels_left_in = pixels_left_ff - 18'd1;
         end
      end

      push_entry.is_pixel    = req_tuser;
      push_entry.dc_data     = dc_active_ff;
      push_entry.x_start     = x_start;
      // end coordinate wraps in 16 bits for a zero size
      push_entry.x_end       = {7'd0, x_start} + {7'd0, win_width} - 16'd1;
      push_entry.y_start     = y_start;
      push_entry.y_end       = {7'd0, y_start} + {7'd0, win_height} - 16'd1;
      push_entry.pixel_value = pixel_value;
      push_entry.window_done = req_tuser && (pixels_left_ff == 18'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_active_ff   <= 1'b1;
         pixels_left_ff <= 18'd0;
      end else begin
         dc_active_ff   <= dc_active_in;
         pixels_left_ff <= pixels_left_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lwps_queue.sv =====
// ----------------------------------------------------------------------------
// lwps_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lwps_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    wr_valid,
   output logic                         wr_ready,
   input  wire lwps_pkg::lwps_entry_type wr_entry,
   output logic                         rd_valid,
   input  wire logic                    rd_ready,
   output lwps_pkg::lwps_entry_type     rd_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   lwps_pkg::lwps_entry_type slots_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = slots_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lwps_back.sv =====
// ----------------------------------------------------------------------------
// lwps_back
// Byte sequencer: walks each queued job one serial byte per cycle into the
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lwps_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     job_valid,
   output logic                          job_pop,
   input  wire lwps_pkg::lwps_entry_type job,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,
   output logic                          rsp_tlast,
   output logic [1:0]                    rsp_tuser
);

   logic [lwps_pkg::IDX_W-1:0] idx_ff;
   logic [lwps_pkg::IDX_W-1:0] idx_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_dc_ff;
   logic       out_last_ff;
   logic       out_done_ff;

   logic       advance;
   logic       load;
   logic       is_last;
   logic [3:0] pair;
   logic [7:0] win_value;
   logic       win_is_cmd;
   logic [7:0] next_byte;
   logic       next_dc;

   assign advance = !out_valid_ff || rsp_tready;
   assign load    = advance && job_valid;
   assign is_last = job.is_pixel ? (idx_ff == lwps_pkg::PIX_LAST_IDX)
                                 : (idx_ff == lwps_pkg::WIN_LAST_IDX);
   assign job_pop = load && is_last;
   assign pair    = idx_ff[lwps_pkg::IDX_W-1:1];

   always_comb begin
      win_is_cmd = 1'b0;
      unique case (pair)
         lwps_pkg::PAIR_COL_CMD: begin
            win_value  = lwps_pkg::CMD_COLUMN;
            win_is_cmd = 1'b1;
         end
         lwps_pkg::PAIR_XS_HI:   win_value = {7'd0, job.x_start[8]};
         lwps_pkg::PAIR_XS_LO:   win_value = job.x_start[7:0];
         lwps_pkg::PAIR_XE_HI:   win_value = job.x_end[15:8];
         lwps_pkg::PAIR_XE_LO:   win_value = job.x_end[7:0];
         lwps_pkg::PAIR_ROW_CMD: begin
            win_value  = lwps_pkg::CMD_ROW;
            win_is_cmd = 1'b1;
         end
         lwps_pkg::PAIR_YS_HI:   win_value = {7'd0, job.y_start[8]};
         lwps_pkg::PAIR_YS_LO:   win_value = job.y_start[7:0];
         lwps_pkg::PAIR_YE_HI:   win_value = job.y_end[15:8];
         lwps_pkg::PAIR_YE_LO:   win_value = job.y_end[7:0];
         lwps_pkg::PAIR_WR_CMD: begin
            win_value  = lwps_pkg::CMD_WRITE;
            win_is_cmd = 1'b1;
         end
         default:                win_value = lwps_pkg::PAD_BYTE;
      endcase

      if (job.is_pixel) begin
         // high byte first
         next_byte = idx_ff[0] ? job.pixel_value[7:0] : job.pixel_value[15:8];
         next_dc   = job.dc_data;
      end else begin
         next_byte = idx_ff[0] ? win_value : lwps_pkg::PAD_BYTE;
         next_dc   = win_is_cmd ? !job.dc_data : job.dc_data;
      end

      idx_in = idx_ff;
      if (load) begin
         idx_in = is_last ? '0 : idx_ff + 1'b1;
      end
      out_valid_in = advance ? job_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= next_byte;
         out_dc_ff   <= next_dc;
         out_last_ff <= is_last;
         out_done_ff <= is_last && job.window_done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_done_ff, out_dc_ff};

endmodule

`default_nettype wire

// ===== sv/lcd_window_pixel_streamer_core.sv =====
// ----------------------------------------------------------------------------
// lcd_window_pixel_streamer_core
// Turns window and pixel words into serial LCD bytes with a data/command level.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per window or pixel. tuser = 0 opens a window
//   (column, row and memory-write commands, 22 bytes); tuser = 1 carries one
//   RGB565 pixel (2 bytes, high byte first).
//   rsp_* carries one byte per transfer with its data/command level, tlast on
//   the final byte of each input word and a window-done flag on the low byte
//   of the window's final pixel.
//   csr_wr_en/csr_wr_data set the line level that means data (reset 1);
//   write it only while the block is idle.
// Timing:
//   The first byte of a word is registered in a queue slot and then in the output register.
//   The byte sequencer emits one byte per cycle while the output is not
//   stalled; a queue of QUEUE_DEPTH jobs lets the input keep accepting
//   while the sequencer works on earlier words.
// Reset and stall:
//   Reset clears the queue, the output register and the pixel count.
//   While rsp_tready is low the output byte holds and, once the queue is
//   full, req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_window_pixel_streamer_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // x_start[8:0], y_start[17:9], win_width[26:18], win_height[35:27],
   // pixel_value[51:36], zero [55:52]
   input  wire logic [55:0] req_tdata,
   // mode
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // spi_byte[7:0]
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   // dc_level[0], window_done[1]
   output logic [1:0]       rsp_tuser
);

   logic                     push_valid;
   logic                     push_ready;
   lwps_pkg::lwps_entry_type push_entry;
   logic                     job_valid;
   logic                     job_pop;
   lwps_pkg::lwps_entry_type job;

   lwps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   lwps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_entry (push_entry),
      .rd_valid (job_valid),
      .rd_ready (job_pop),
      .rd_entry (job)
   );

   lwps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_pop    (job_pop),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== sv/lwps_checker.sv =====
// ----------------------------------------------------------------------------
// lwps_checker
// Port-level checks on the streamer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lwps_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic [1:0] rsp_tuser
);

   // hold a stalled byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp byte changed while stalled");

   // window done only ever marks the final byte of a pixel
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("window_done without tlast");

   // reset empties the output register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind lcd_window_pixel_streamer_core lwps_checker u_lwps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks lcd_window_pixel_streamer_core against its own byte predictor.
// A short directed table covers zero size, wrap of the end coordinate, the
// largest window, pixels with no open window and a window reload mid-window.
// Then come random window/pixel sequences under three idle patterns and both
// data/command levels. Every output word is compared with the oldest
// predicted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_WINDOW = 1'b0;
   localparam logic MODE_PIXEL  = 1'b1;
   localparam int   STALL_LIMIT = 2000;
   localparam int   NUM_DIRECTED = 18;

   // one input word; the typed fields hold a hand-written expectation
   typedef struct packed {
      logic        mode;
      logic [8:0]  xs;
      logic [8:0]  ys;
      logic [8:0]  w;
      logic [8:0]  h;
      logic [15:0] pix;
      logic        typed;
      logic [15:0] xe_t;
      logic [15:0] ye_t;
      logic        done_t;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       dc;
      logic       last;
      logic       done;
   } spi_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   int source_idle_pct = 0;
   int sink_idle_pct = 0;
   int error_count = 0;
   int stall_cycles = 0;

   // predictor state
   logic         data_level = 1'b1;
   logic [17:0]  pixels_pending = '0;
   spi_byte_type expected_bytes[$];

   stim_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      // pixels before any window
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'hffff, 1'b1, 16'h0, 16'h0, 1'b0},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0000, 1'b1, 16'h0, 16'h0, 1'b0},
      // zero size wraps the end coordinate
      '{MODE_WINDOW, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 1'b1, 16'hffff, 16'hffff, 1'b0},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h1234, 1'b1, 16'h0, 16'h0, 1'b0},
      '{MODE_WINDOW, 9'd511, 9'd511, 9'd511, 9'd511, 16'h0, 1'b1, 16'h03fd, 16'h03fd,
        1'b0},
      '{MODE_WINDOW, 9'd479, 9'd0, 9'd1, 9'd2, 16'h0, 1'b1, 16'h01df, 16'h0001, 1'b0},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'ha55a, 1'b1, 16'h0, 16'h0, 1'b0},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h5aa5, 1'b1, 16'h0, 16'h0, 1'b1},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h8001, 1'b1, 16'h0, 16'h0, 1'b0},
      '{MODE_WINDOW, 9'd0, 9'd479, 9'd480, 9'd1, 16'h0, 1'b1, 16'h01df, 16'h01df, 1'b0},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h00ff, 1'b0, 16'h0, 16'h0, 1'b0},
      // reload in the middle of a window
      '{MODE_WINDOW, 9'd10, 9'd20, 9'd1, 9'd1, 16'h0, 1'b1, 16'd10, 16'd20, 1'b0},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'hff00, 1'b1, 16'h0, 16'h0, 1'b1},
      '{MODE_WINDOW, 9'd1, 9'd256, 9'd256, 9'd256, 16'h0, 1'b1, 16'h0100, 16'h01ff,
        1'b0},
      '{MODE_WINDOW, 9'd2, 9'd3, 9'd2, 9'd1, 16'h0, 1'b0, 16'h0, 16'h0, 1'b0},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h7e0f, 1'b0, 16'h0, 16'h0, 1'b0},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'hf81f, 1'b1, 16'h0, 16'h0, 1'b1},
      '{MODE_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h07e0, 1'b1, 16'h0, 16'h0, 1'b0}
   };

   lcd_window_pixel_streamer_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
   end

   task automatic push_byte(input logic [7:0] data, input logic dc, input logic last,
                            input logic done);
      spi_byte_type b;
      b.data = data;
      b.dc = dc;
      b.last = last;
      b.done = done;
      expected_bytes.push_back(b);
   endtask

   task automatic push_pair(input logic [7:0] value, input logic dc);
      push_byte(lwps_pkg::PAD_BYTE, dc, 1'b0, 1'b0);
      push_byte(value, dc, 1'b0, 1'b0);
   endtask

   task automatic push_range(input logic [7:0] cmd, input logic [15:0] first,
                             input logic [15:0] final_coord);
      push_pair(cmd, ~data_level);
      push_pair(first[15:8], data_level);
      push_pair(first[7:0], data_level);
      push_pair(final_coord[15:8], data_level);
      push_pair(final_coord[7:0], data_level);
   endtask

   // work out the bytes of one accepted word and advance the pixel count
   task automatic predict_word(input stim_row_type r);
      logic [15:0] x_end;
      logic [15:0] y_end;
      logic        done;
      if (r.mode == MODE_WINDOW) begin
         x_end = 16'(r.xs) + 16'(r.w) - 16'd1;
         y_end = 16'(r.ys) + 16'(r.h) - 16'd1;
         if (r.typed) begin
            x_end = r.xe_t;
            y_end = r.ye_t;
         end
         pixels_pending = 18'(r.w) * 18'(r.h);
         push_range(lwps_pkg::CMD_COLUMN, 16'(r.xs), x_end);
         push_range(lwps_pkg::CMD_ROW, 16'(r.ys), y_end);
         push_pair(lwps_pkg::CMD_WRITE, ~data_level);
         expected_bytes[expected_bytes.size()-1].last = 1'b1;
      end else begin
         done = 1'b0;
         if (pixels_pending != 18'd0) begin
            pixels_pending = pixels_pending - 18'd1;
            done = (pixels_pending == 18'd0);
         end
         if (r.typed)
            done = r.done_t;
         push_byte(r.pix[15:8], data_level, 1'b0, 1'b0);
         push_byte(r.pix[7:0], data_level, 1'b1, done);
      end
   endtask

   task automatic send_row(input stim_row_type r);
      while ($urandom_range(99) < source_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, r.pix, r.h, r.w, r.ys, r.xs};
      req_tuser <= r.mode;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_word(r);
   endtask

   // hold the input until every predicted byte has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_data_level(input logic level);
      drain_results();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      data_level = level;
   endtask

   function automatic stim_row_type random_row(input logic mode);
      stim_row_type r;
      r.mode = mode;
      r.xs = 9'($urandom_range(511));
      r.ys = 9'($urandom_range(511));
      r.w = 9'($urandom_range(511));
      r.h = 9'($urandom_range(511));
      r.pix = 16'($urandom_range(65535));
      r.typed = 1'b0;
      r.xe_t = '0;
      r.ye_t = '0;
      r.done_t = 1'b0;
      return r;
   endfunction

   // mostly small windows followed by their pixels, some cut short or overrun
   task automatic run_random(input int target);
      int           sent;
      int           roll;
      int           pixel_total;
      stim_row_type r;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(99) < 3)
            drain_results();
         roll = $urandom_range(99);
         if (roll < 80) begin
            r = random_row(MODE_WINDOW);
            if (roll < 8) begin
               r.w = 9'($urandom_range(8));
               r.h = 9'($urandom_range(8));
            end else begin
               r.w = 9'($urandom_range(1, 4));
               r.h = 9'($urandom_range(1, 4));
            end
            send_row(r);
            sent++;
            pixel_total = int'(r.w) * int'(r.h);
            case ($urandom_range(9))
               0: pixel_total = $urandom_range(pixel_total);
               1: pixel_total = pixel_total + $urandom_range(1, 3);
               default: ;
            endcase
            repeat (pixel_total) begin
               send_row(random_row(MODE_PIXEL));
               sent++;
            end
         end else if (roll < 90) begin
            send_row(random_row(MODE_WINDOW));
            sent++;
         end else begin
            send_row(random_row(MODE_PIXEL));
            sent++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input spi_byte_type exp_b,
                                  input spi_byte_type act_b);
      if (error_count < 10) begin
         $write("%0t: %s: expected byte %02h dc %0b last %0b done %0b",
                $realtime, what, exp_b.data, exp_b.dc, exp_b.last, exp_b.done);
         $display(", got %02h dc %0b last %0b done %0b",
                  act_b.data, act_b.dc, act_b.last, act_b.done);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      spi_byte_type got;
      spi_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data = rsp_tdata;
         got.dc = rsp_tuser[0];
         got.last = rsp_tlast;
         got.done = rsp_tuser[1];
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected word", '0, got);
         end else begin
            want = expected_bytes.pop_front();
            if (got != want)
               report_mismatch("mismatch", want, got);
         end
      end
   end

   // end the run when no word moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      source_idle_pct = 33;
      sink_idle_pct = 73;
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_row(directed_rows[i]);
      set_data_level(1'b0);
      run_random(150);

      set_data_level(1'b1);
      source_idle_pct = 73;
      sink_idle_pct = 33;
      run_random(150);

      set_data_level(1'($urandom_range(1)));
      source_idle_pct = 0;
      sink_idle_pct = 0;
      run_random(155);

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/lwps_pkg.sv
sv/lwps_front.sv
sv/lwps_queue.sv
sv/lwps_back.sv
sv/lcd_window_pixel_streamer_core.sv
sv/lwps_checker.sv
test/testbench.sv
